### design/assert_macros.svh
// Assertion macros shared by the converter modules.
// Each macro samples on i_clk and is quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define YUVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define YUVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/yuvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvc_pkg
// Shared types, constants and helpers of the YUV 4:2:0 to BGRA converter.
// ----------------------------------------------------------------------------
package yuvc_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // configuration port
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // BT.601 limited-range coefficients (8 fractional bits)
    localparam int SUM_W = 20;
    localparam logic signed [SUM_W-1:0] K_Y     = 20'sd298;
    localparam logic signed [SUM_W-1:0] K_RV    = 20'sd409;
    localparam logic signed [SUM_W-1:0] K_GU    = 20'sd100;
    localparam logic signed [SUM_W-1:0] K_GV    = 20'sd208;
    localparam logic signed [SUM_W-1:0] K_BU    = 20'sd516;
    localparam logic signed [SUM_W-1:0] K_ROUND = 20'sd128;
    localparam logic signed [8:0]       Y_OFFSET = 9'sd16;
    localparam logic [7:0]              ALPHA    = 8'hFF;

    // item waiting for its chroma pair from the line buffer
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       use_in;     // pair comes with the item, not from memory
        logic       row_end;
        logic       frame_end;
    } t_s1;

    // fixed-point sum to 0..255: drop 8 fraction bits, saturate
    function automatic logic [7:0] f_clamp(input logic signed [SUM_W-1:0] s);
        logic [7:0] q;
        if (s[SUM_W-1]) begin
            q = 8'd0;
        end else if (|s[SUM_W-2:16]) begin
            q = 8'd255;
        end else begin
            q = s[15:8];
        end
        return q;
    endfunction

endpackage

### design/yuvc_pix_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvc_pix_in_if
// Input pixel channel: one luma sample with an optional chroma pair.
// ----------------------------------------------------------------------------
interface yuvc_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;

    modport source (output valid, output luma, output chroma_u, output chroma_v,
                    input ready);
    modport sink   (input valid, input luma, input chroma_u, input chroma_v,
                    output ready);
endinterface

### design/yuvc_pix_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvc_pix_out_if
// Output pixel channel: packed BGRA word with row and frame end marks.
// ----------------------------------------------------------------------------
interface yuvc_pix_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_bgra;
    logic        row_end;
    logic        frame_end;

    modport source (output valid, output pixel_bgra, output row_end,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel_bgra, input row_end,
                    input frame_end, output ready);
endinterface

### design/yuvc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module yuvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/yuvc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvc_seq
// Size registers, raster position counters and chroma line buffer access.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yuvc_seq import yuvc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2,
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    yuvc_pix_in_if.sink          i_pix,
    output t_s1                  o_s1,
    output logic                 o_s1_vld,
    input  logic                 i_take,
    output logic                 o_ram_we,
    output logic                 o_ram_re,
    output logic [IDX_W-1:0]     o_ram_addr,
    output logic [15:0]          o_ram_wdata
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WEXT_W = (CFG_W > WSZ_W) ? CFG_W : WSZ_W;
    localparam int HEXT_W = (CFG_W > HSZ_W) ? CFG_W : HSZ_W;

    logic [CFG_W-1:0]  r_width, r_height;
    logic [CNT_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_s1_vld;
    t_s1               r_s1;

    logic [WEXT_W-1:0] w_ext, w_last_ext;
    logic [HEXT_W-1:0] h_ext, h_last_ext;
    logic [CNT_W-1:0]  w_last, col;
    logic [ROW_W-1:0]  h_last, row;
    logic              last_col, last_row, acc, chroma_wr;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    // last column / row of the frame; zero acts as one, oversize saturates
    always_comb begin
        w_ext = WEXT_W'(r_width);
        h_ext = HEXT_W'(r_height);
        if (r_width == '0) begin
            w_last_ext = '0;
        end else if (w_ext > WEXT_W'(MAX_WIDTH)) begin
            w_last_ext = WEXT_W'(MAX_WIDTH - 1);
        end else begin
            w_last_ext = w_ext - 1'b1;
        end
        if (r_height == '0) begin
            h_last_ext = '0;
        end else if (h_ext > HEXT_W'(MAX_HEIGHT)) begin
            h_last_ext = HEXT_W'(MAX_HEIGHT - 1);
        end else begin
            h_last_ext = h_ext - 1'b1;
        end
        w_last = CNT_W'(w_last_ext);
        h_last = ROW_W'(h_last_ext);
    end

    // a counter past the end of a shrunk frame sits on the last position
    assign col      = (r_col > w_last) ? w_last : r_col;
    assign row      = (r_row > h_last) ? h_last : r_row;
    assign last_col = (col == w_last);
    assign last_row = (row == h_last);

    assign i_pix.ready = !r_s1_vld || i_take;
    assign acc         = i_pix.valid && i_pix.ready;
    assign chroma_wr   = !row[0] && !col[0];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : row + 1'b1;
            end else begin
                n_col = col + 1'b1;
                n_row = row;
            end
        end
    end

    // one access per transaction: either store the incoming pair or fetch one.
    // Writes land before any later read, so no bypass is needed.
    assign o_ram_we    = acc && chroma_wr;
    assign o_ram_re    = acc && !chroma_wr;
    assign o_ram_addr  = IDX_W'(col >> 1);
    assign o_ram_wdata = {i_pix.chroma_u, i_pix.chroma_v};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (i_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1.luma      <= i_pix.luma;
            r_s1.chroma_u  <= i_pix.chroma_u;
            r_s1.chroma_v  <= i_pix.chroma_v;
            r_s1.use_in    <= chroma_wr;
            r_s1.row_end   <= last_col;
            r_s1.frame_end <= last_col && last_row;
        end
    end

    assign o_s1     = r_s1;
    assign o_s1_vld = r_s1_vld;

    `YUVC_ASSERT(a_ram_one_access, !(o_ram_we && o_ram_re), "ram read and write together")
    `YUVC_ASSERT_NEXT(a_col_wrap, acc && last_col, r_col == '0, "column did not wrap")
    `YUVC_ASSERT_NEXT(a_frame_wrap, acc && last_col && last_row, r_row == '0,
                      "row did not wrap at frame end")

endmodule

### design/yuvc_csc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvc_csc
// BT.601 color conversion: coefficient products, sums with clamp, output reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yuvc_csc import yuvc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_s1             i_s1,
    input  logic            i_s1_vld,
    input  logic [15:0]     i_ram_rdata,
    output logic            o_take,
    yuvc_pix_out_if.source  o_pix
);

    logic signed [8:0]       c;
    logic signed [7:0]       d, e;
    logic [7:0]              u, v;
    logic signed [SUM_W-1:0] p_y, p_rv, p_gu, p_gv, p_bu;

    logic                    r_s2_vld;
    logic signed [SUM_W-1:0] r_y, r_rv, r_gu, r_gv, r_bu;
    logic                    r_s2_row_end, r_s2_frame_end;
    logic                    s2_take;

    logic signed [SUM_W-1:0] s_r, s_g, s_b;
    logic                    r_out_vld;
    logic [31:0]             r_pixel;
    logic                    r_row_end, r_frame_end;

    // each stage advances when its successor is empty or moving
    assign s2_take = !r_out_vld || o_pix.ready;
    assign o_take  = !r_s2_vld || s2_take;

    // pair from the item itself when it was just stored, else from memory
    always_comb begin
        u    = i_s1.use_in ? i_s1.chroma_u : i_ram_rdata[15:8];
        v    = i_s1.use_in ? i_s1.chroma_v : i_ram_rdata[7:0];
        c    = $signed({1'b0, i_s1.luma}) - Y_OFFSET;
        d    = $signed({~u[7], u[6:0]});
        e    = $signed({~v[7], v[6:0]});
        p_y  = SUM_W'(c) * K_Y + K_ROUND;
        p_rv = SUM_W'(e) * K_RV;
        p_gu = SUM_W'(d) * K_GU;
        p_gv = SUM_W'(e) * K_GV;
        p_bu = SUM_W'(d) * K_BU;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (o_take) begin
            r_s2_vld <= i_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_s1_vld) begin
            r_y            <= p_y;
            r_rv           <= p_rv;
            r_gu           <= p_gu;
            r_gv           <= p_gv;
            r_bu           <= p_bu;
            r_s2_row_end   <= i_s1.row_end;
            r_s2_frame_end <= i_s1.frame_end;
        end
    end

    always_comb begin
        s_r = r_y + r_rv;
        s_g = r_y - r_gu - r_gv;
        s_b = r_y + r_bu;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_take) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take && r_s2_vld) begin
            r_pixel     <= {ALPHA, f_clamp(s_r), f_clamp(s_g), f_clamp(s_b)};
            r_row_end   <= r_s2_row_end;
            r_frame_end <= r_s2_frame_end;
        end
    end

    assign o_pix.valid      = r_out_vld;
    assign o_pix.pixel_bgra = r_pixel;
    assign o_pix.row_end    = r_row_end;
    assign o_pix.frame_end  = r_frame_end;

    `YUVC_ASSERT_NEXT(a_s2_hold, r_s2_vld && r_out_vld && !o_pix.ready, r_s2_vld,
                      "stage two lost an item under stall")
    `YUVC_ASSERT(a_frame_has_row, !r_out_vld || !r_frame_end || r_row_end,
                 "frame end without row end")

endmodule

### design/yuv420_to_bgra_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_bgra_converter_unit
// BT.601 limited-range YUV 4:2:0 pixel stream to packed BGRA with row and
// frame marks; chroma pairs of even rows held in a half-width line RAM.
//
//   channel  dir  handshake        payload
//   i_pix    in   valid/ready      luma, chroma_u, chroma_v
//   o_pix    out  valid/ready      pixel_bgra, row_end, frame_end
//   cfg      in   i_cfg_we         i_cfg_idx, i_cfg_wdata
//
// One pixel per clock sustained while o_pix is ready. An input transaction
// reaches output valid through the stage-one register with the line RAM
// read, the product register and the output register. Each transaction
// makes one line RAM access (store or fetch). Reset clears counters,
// pipeline valids and restores 640x480; the line RAM needs no clearing
// pass. Up to three transactions are held inside; once all three stages are
// full, input ready follows output ready in the same cycle.
// ----------------------------------------------------------------------------
module yuv420_to_bgra_converter_unit import yuvc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    yuvc_pix_in_if.sink          i_pix,
    yuvc_pix_out_if.source       o_pix
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    t_s1              s1;
    logic             s1_vld, take;
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_addr;
    logic [15:0]      ram_wdata, ram_rdata;

    yuvc_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (i_pix),
        .o_s1        (s1),
        .o_s1_vld    (s1_vld),
        .i_take      (take),
        .o_ram_we    (ram_we),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata)
    );

    yuvc_ram #(
        .WIDTH (16),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    yuvc_csc u_csc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1),
        .i_s1_vld    (s1_vld),
        .i_ram_rdata (ram_rdata),
        .o_take      (take),
        .o_pix       (o_pix)
    );

endmodule
